// ===== sv/cmbg_pkg.sv =====
`timescale 1ns / 1ps

package cmbg_pkg;

	// configuration write channel widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register field widths
	localparam int GAIN_W  = 32;
	localparam int SEED_W  = 32;
	localparam int SKIP_W  = 16;
	localparam int VALUE_W = 8;

	// digit width of the shared multiplier (state side)
	localparam int DIGIT_W = 16;

	// packer geometry
	localparam int PACK_CNT_W = 3;
	localparam logic [PACK_CNT_W-1:0] PACK_LAST = 3'd7;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_NEG  = 3'd0,
		REG_GAIN_POS  = 3'd1,
		REG_SEED      = 3'd2,
		REG_SKIP      = 3'd3,
		REG_PACK_MODE = 3'd4
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_EMIT
	} seq_state_t;

endpackage

// ===== sv/cmbg_in_if.sv =====
`timescale 1ns / 1ps

interface cmbg_in_if;
	logic valid;
	logic ready;
	logic reseed;

	modport source (output valid, output reseed, input ready);
	modport sink (input valid, input reseed, output ready);
endinterface

// ===== sv/cmbg_out_if.sv =====
`timescale 1ns / 1ps

interface cmbg_out_if;
	logic                         valid;
	logic                         ready;
	logic [cmbg_pkg::VALUE_W-1:0] out_value;

	modport source (output valid, output out_value, input ready);
	modport sink (input valid, input out_value, output ready);
endinterface

// ===== sv/cmbg_cfg_if.sv =====
`timescale 1ns / 1ps

interface cmbg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cmbg_pkg::CFG_IDX_W-1:0]  index;
	logic [cmbg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/chaotic_map_bit_generator.sv =====
`timescale 1ns / 1ps

// Piecewise linear chaotic map bit source.
// in_ch: one beat per request. reseed=1 loads seed_value into the map state and
// clears the byte packer (no result); reseed=0 runs skip_count discarded map
// iterations and one output iteration whose starting sign gives the bit.
// out_ch: bit mode gives the bit in bit 0; packed mode gives one byte (first bit
// in bit 7) after every eighth request, nothing for the others.
// cfg_ch: register writes by index, always ready; write only while idle.
// One map iteration runs on a single 32 x 17 multiplier fed one 16-bit state
// digit per cycle, then a shift, add and saturate step; the state is split into
// ND = ceil(STATE_WIDTH / 16) digits.
// A request runs skip_count + 1 map iterations from its accept beat until the
// result is loaded into the output register; a reseed keeps in_ch ready.
// in_ch is not ready from a request's accept beat until its result is loaded, so
// a new request is not taken before the last one is through.
// The output register holds a result until taken; a new request may be accepted
// meanwhile and waits before loading its own result while the receiver stalls.
// Reset loads register defaults and clears the map state and the packer.
module chaotic_map_bit_generator #(
	parameter int STATE_WIDTH = 32,
	parameter int FRAC_BITS   = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	cmbg_cfg_if.sink      cfg_ch,
	cmbg_in_if.sink       in_ch,
	cmbg_out_if.source    out_ch
);

	localparam int DW   = cmbg_pkg::DIGIT_W;
	localparam int ND   = (STATE_WIDTH + DW - 1) / DW;
	localparam int XW   = ND * DW;
	localparam int AW   = XW + cmbg_pkg::GAIN_W + 1;
	localparam int DGW  = (ND > 1) ? $clog2(ND) : 1;
	localparam int SUMW = ((AW > FRAC_BITS + 2) ? AW : FRAC_BITS + 2) + 1;
	localparam int EW   = (STATE_WIDTH > cmbg_pkg::SEED_W) ? STATE_WIDTH : cmbg_pkg::SEED_W;
	localparam int PW   = cmbg_pkg::GAIN_W + DW + 1;

	localparam logic [DGW-1:0]         DIG_TOP = DGW'(ND - 1);
	localparam logic signed [SUMW-1:0] ONE     = SUMW'(1) <<< FRAC_BITS;
	localparam logic [STATE_WIDTH-1:0] SAT_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	localparam logic [STATE_WIDTH-1:0] SAT_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

	cmbg_pkg::seq_state_t st_q, st_d;

	logic [cmbg_pkg::GAIN_W-1:0]     gneg_q, gpos_q;
	logic [cmbg_pkg::SEED_W-1:0]     seed_q;
	logic [cmbg_pkg::SKIP_W-1:0]     skip_q, iter_q;
	logic                            packed_q;
	logic [STATE_WIDTH-1:0]          map_q;
	logic [AW-1:0]                   acc_q;
	logic [DGW-1:0]                  dig_q;
	logic                            bit_q;
	logic [cmbg_pkg::PACK_CNT_W-1:0] cnt_q;
	logic [cmbg_pkg::VALUE_W-1:0]    byte_q, odata_q, byte_new;
	logic                            oval_q;

	logic                     in_acc, cfg_acc, slot_free, need_out, emit_go;
	logic signed [XW-1:0]     x_ext;
	logic [DW-1:0]            digit;
	logic signed [DW:0]       digit_s;
	logic [cmbg_pkg::GAIN_W-1:0] gain;
	logic signed [PW-1:0]     prod;
	logic [AW-1:0]            acc_base, acc_next;
	logic signed [AW-1:0]     shifted;
	logic signed [SUMW-1:0]   sum;
	logic [SUMW-STATE_WIDTH:0] sum_top;
	logic [STATE_WIDTH-1:0]   iter_res;
	logic signed [EW-1:0]     seed_ext;
	logic [EW-STATE_WIDTH:0]  seed_top;
	logic [STATE_WIDTH-1:0]   seed_sat;
	logic [cmbg_pkg::PACK_CNT_W-1:0] pos;

	// handshakes
	assign cfg_ch.ready = 1'b1;
	assign cfg_acc      = cfg_ch.valid;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid     = oval_q;
	assign out_ch.out_value = odata_q;

	// multiplier digit step: one signed state digit times the selected gain
	assign x_ext   = XW'($signed(map_q));
	assign digit   = x_ext[dig_q*DW +: DW];
	assign digit_s = {(dig_q == DIG_TOP) & digit[DW-1], digit};
	assign gain    = map_q[STATE_WIDTH-1] ? gneg_q : gpos_q;
	assign prod    = $signed(gain) * digit_s;
	assign acc_base = (dig_q == DIG_TOP) ? '0 : (acc_q << DW);
	assign acc_next = acc_base + AW'(prod);

	// finish step: rescale, add or subtract one, saturate
	assign shifted  = $signed(acc_q) >>> FRAC_BITS;
	assign sum      = map_q[STATE_WIDTH-1] ? (SUMW'(shifted) + ONE) : (SUMW'(shifted) - ONE);
	assign sum_top  = sum[SUMW-1:STATE_WIDTH-1];
	assign iter_res = ((&sum_top) || !(|sum_top)) ? sum[STATE_WIDTH-1:0]
	                : (sum[SUMW-1] ? SAT_MIN : SAT_MAX);

	// seed load with saturation to the state width
	assign seed_ext = EW'($signed(seed_q));
	assign seed_top = seed_ext[EW-1:STATE_WIDTH-1];
	assign seed_sat = ((&seed_top) || !(|seed_top)) ? seed_ext[STATE_WIDTH-1:0]
	                : (seed_ext[EW-1] ? SAT_MIN : SAT_MAX);

	// packer insert, msb first
	assign pos      = cmbg_pkg::PACK_LAST - cnt_q;
	assign byte_new = byte_q | (cmbg_pkg::VALUE_W'(bit_q) << pos);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			cmbg_pkg::ST_IDLE: begin
				if (in_acc && !in_ch.reseed) st_d = cmbg_pkg::ST_MUL;
			end
			cmbg_pkg::ST_MUL: begin
				if (dig_q == '0) st_d = cmbg_pkg::ST_FIN;
			end
			cmbg_pkg::ST_FIN: begin
				st_d = (iter_q == '0) ? cmbg_pkg::ST_EMIT : cmbg_pkg::ST_MUL;
			end
			cmbg_pkg::ST_EMIT: begin
				if (emit_go) st_d = cmbg_pkg::ST_IDLE;
			end
			default: st_d = cmbg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ch.ready = (st_q == cmbg_pkg::ST_IDLE);
		slot_free   = !oval_q || out_ch.ready;
		need_out    = !packed_q || (cnt_q == cmbg_pkg::PACK_LAST);
		emit_go     = (st_q == cmbg_pkg::ST_EMIT) && (!need_out || slot_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= cmbg_pkg::ST_IDLE;
			gneg_q   <= 32'h1800_0000;
			gpos_q   <= 32'h1800_0000;
			seed_q   <= '0;
			skip_q   <= '0;
			packed_q <= 1'b0;
			map_q    <= '0;
			iter_q   <= '0;
			dig_q    <= '0;
			bit_q    <= 1'b0;
			cnt_q    <= '0;
			byte_q   <= '0;
			oval_q   <= 1'b0;
		end else begin
			st_q <= st_d;

			// register writes
			if (cfg_acc) begin
				case (cmbg_pkg::cfg_reg_t'(cfg_ch.index))
					cmbg_pkg::REG_GAIN_NEG:  gneg_q   <= cfg_ch.data;
					cmbg_pkg::REG_GAIN_POS:  gpos_q   <= cfg_ch.data;
					cmbg_pkg::REG_SEED:      seed_q   <= cfg_ch.data;
					cmbg_pkg::REG_SKIP:      skip_q   <= cfg_ch.data[cmbg_pkg::SKIP_W-1:0];
					cmbg_pkg::REG_PACK_MODE: packed_q <= cfg_ch.data[0];
					default: ;
				endcase
			end

			// request start or reseed
			if (in_acc) begin
				if (in_ch.reseed) begin
					map_q  <= seed_sat;
					cnt_q  <= '0;
					byte_q <= '0;
				end else begin
					iter_q <= skip_q;
					dig_q  <= DIG_TOP;
				end
			end

			// digit walk
			if (st_q == cmbg_pkg::ST_MUL && dig_q != '0) dig_q <= dig_q - 1'b1;

			// iteration end
			if (st_q == cmbg_pkg::ST_FIN) begin
				map_q <= iter_res;
				bit_q <= !map_q[STATE_WIDTH-1];
				dig_q <= DIG_TOP;
				if (iter_q != '0) iter_q <= iter_q - 1'b1;
			end

			// result and packer update
			if (emit_go && packed_q) begin
				if (need_out) begin
					cnt_q  <= '0;
					byte_q <= '0;
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					byte_q <= byte_new;
				end
			end

			if (emit_go && need_out) oval_q <= 1'b1;
			else if (out_ch.ready) oval_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == cmbg_pkg::ST_MUL) acc_q <= acc_next;
		if (emit_go && need_out) odata_q <= packed_q ? byte_new : cmbg_pkg::VALUE_W'(bit_q);
	end

endmodule

// ===== sv/cmbg_checker.sv =====
`timescale 1ns / 1ps

module cmbg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         reseed,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [cmbg_pkg::VALUE_W-1:0] out_value
);

	logic in_beat;
	assign in_beat = in_valid && in_ready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("output beat dropped or changed while stalled");

	// a request beat closes the input until its iterations finish
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !reseed |=> !in_ready)
		else $error("input ready right after a request beat");

	// a reseed beat leaves the input ready
	a_reseed_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && reseed |=> in_ready)
		else $error("input not ready after a reseed beat");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_beat, 1) && !$past(in_beat, 2))
		else $error("result appeared too soon after a request beat");

endmodule

bind chaotic_map_bit_generator cmbg_checker u_cmbg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.reseed    (in_ch.reseed),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.out_value)
);

// ===== tb/chaotic_map_bit_generator_test.sv =====
`timescale 1ns / 1ps

module chaotic_map_bit_generator_test;

	localparam int ST_W      = 32;
	localparam int FRAC_W    = 28;
	localparam int RAND_BEATS = 1850;

	typedef enum {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE
	} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cmbg_cfg_if cfg_bus ();
	cmbg_in_if  req_bus ();
	cmbg_out_if val_bus ();

	chaotic_map_bit_generator #(
		.STATE_WIDTH(ST_W),
		.FRAC_BITS  (FRAC_W)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg_ch(cfg_bus),
		.in_ch (req_bus),
		.out_ch(val_bus)
	);

	always #4 clk = ~clk;

	// shadow registers and map state of the generator
	logic signed [cmbg_pkg::GAIN_W-1:0] k_neg     = 32'h1800_0000;
	logic signed [cmbg_pkg::GAIN_W-1:0] k_pos     = 32'h1800_0000;
	logic signed [cmbg_pkg::SEED_W-1:0] seed_reg  = '0;
	logic [cmbg_pkg::SKIP_W-1:0]        skip_len  = '0;
	logic                               pack_on   = 1'b0;
	logic signed [ST_W-1:0]             map_x     = '0;
	logic [3:0]                         pack_count = '0;
	logic [cmbg_pkg::VALUE_W-1:0]       pack_byte = '0;
	bit                                 last_silent = 1'b0;

	logic                         request_queue[$];
	logic [cmbg_pkg::VALUE_W-1:0] owed_values[$];
	logic [cmbg_pkg::VALUE_W-1:0] want_value;
	int                           err_count = 0;

	bit          req_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	rx_pattern_t rx_mode = RX_OPEN;
	int          rx_left = 0;
	int          hold_cycles = 0;

	task automatic report_mismatch(input string what);
		err_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// one map step: exact product, floor shift, add or subtract one, saturate
	function automatic logic signed [ST_W-1:0] map_iterate(input logic signed [ST_W-1:0] x);
		longint prod;
		longint sum;
		prod = longint'(x) * longint'(x[ST_W-1] ? k_neg : k_pos);
		prod = prod >>> FRAC_W;
		sum = x[ST_W-1] ? prod + (64'sd1 <<< FRAC_W) : prod - (64'sd1 <<< FRAC_W);
		if (sum > longint'(32'sh7fff_ffff))
			return 32'sh7fff_ffff;
		if (sum < -longint'(64'sh8000_0000))
			return 32'sh8000_0000;
		return sum[ST_W-1:0];
	endfunction

	// advance the shadow generator by one accepted request beat
	task automatic advance_generator(input logic reseed_bit);
		logic out_bit;
		if (reseed_bit) begin
			map_x = seed_reg;
			pack_count = '0;
			pack_byte = '0;
			last_silent = 1'b1;
			return;
		end
		for (int i = 0; i < int'(skip_len); i++)
			map_x = map_iterate(map_x);
		out_bit = ~map_x[ST_W-1];
		map_x = map_iterate(map_x);
		if (!pack_on) begin
			owed_values.push_back({{(cmbg_pkg::VALUE_W-1){1'b0}}, out_bit});
			last_silent = 1'b0;
			return;
		end
		pack_count = pack_count & 4'd7;
		pack_byte[cmbg_pkg::PACK_LAST - pack_count[cmbg_pkg::PACK_CNT_W-1:0]] = out_bit;
		if (pack_count[cmbg_pkg::PACK_CNT_W-1:0] == cmbg_pkg::PACK_LAST) begin
			owed_values.push_back(pack_byte);
			pack_byte = '0;
			pack_count = '0;
			last_silent = 1'b0;
		end else begin
			pack_count = pack_count + 4'd1;
			last_silent = 1'b1;
		end
	endtask

	// register write over the config channel, shadow copy updated on the beat
	task automatic write_reg(input logic [cmbg_pkg::CFG_IDX_W-1:0] idx,
		input logic [cmbg_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			cmbg_pkg::REG_GAIN_NEG:  k_neg = value;
			cmbg_pkg::REG_GAIN_POS:  k_pos = value;
			cmbg_pkg::REG_SEED:      seed_reg = value;
			cmbg_pkg::REG_SKIP:      skip_len = value[cmbg_pkg::SKIP_W-1:0];
			cmbg_pkg::REG_PACK_MODE: pack_on = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic queue_beats(input int count, input logic reseed_bit);
		for (int i = 0; i < count; i++)
			request_queue.push_back(reseed_bit);
	endtask

	// sender and receiver both quiet; silent tail still gets the iteration latency
	task automatic wait_idle();
		while (request_queue.size() != 0 || req_bus.valid || owed_values.size() != 0)
			@(posedge clk);
		if (last_silent)
			repeat ((int'(skip_len) + 1) * 4 + 8) @(posedge clk);
	endtask

	function automatic logic [cmbg_pkg::GAIN_W-1:0] pick_gain();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return 32'h1000_0000 + $urandom_range(0, 32'h1000_0000);
	endfunction

	function automatic logic [cmbg_pkg::SEED_W-1:0] pick_seed();
		if ($urandom_range(0, 5) == 0)
			return $urandom;
		return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
	endfunction

	// request beat accepted: predict its results
	always @(posedge clk) begin
		if (arst_n && req_bus.valid && req_bus.ready) begin
			advance_generator(req_bus.reseed);
			req_taken = 1'b1;
		end
	end

	// request driver: bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (req_taken || !req_bus.valid) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				req_bus.valid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				req_bus.valid  <= 1'b1;
				req_bus.reseed <= request_queue.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// receiver ready pattern, with an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			val_bus.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				case ($urandom_range(0, 3))
					0, 1: rx_mode = RX_OPEN;
					2: rx_mode = RX_COIN;
					default: rx_mode = RX_SPARSE;
				endcase
				rx_left = $urandom_range(16, 200);
			end else begin
				rx_left--;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				val_bus.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: val_bus.ready <= 1'b1;
					RX_COIN: val_bus.ready <= ($urandom_range(0, 1) == 1);
					default: val_bus.ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// result beat: compare against the oldest owed value
	always @(posedge clk) begin
		if (arst_n && val_bus.valid && val_bus.ready) begin
			if (owed_values.size() == 0) begin
				report_mismatch($sformatf("unexpected out_value %0h", val_bus.out_value));
			end else begin
				want_value = owed_values.pop_front();
				if (val_bus.out_value !== want_value)
					report_mismatch($sformatf("out_value %0h, want %0h",
						val_bus.out_value, want_value));
			end
		end
	end

	initial begin
		#40_000_000;
		$display("chaotic_map_bit_generator_test: errors");
		$finish;
	end

	initial begin
		int issued;
		int phase;
		int count;

		cfg_bus.valid  = 1'b0;
		cfg_bus.index  = '0;
		cfg_bus.data   = '0;
		req_bus.valid  = 1'b0;
		req_bus.reseed = 1'b0;
		val_bus.ready  = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: zero state, bit mode
		queue_beats(1, 1'b0);
		wait_idle();

		// extreme gains and seeds drive the sum into saturation
		write_reg(cmbg_pkg::REG_GAIN_NEG, 32'h7fff_ffff);
		write_reg(cmbg_pkg::REG_GAIN_POS, 32'h8000_0000);
		write_reg(cmbg_pkg::REG_SEED, 32'h7fff_ffff);
		write_reg(cmbg_pkg::REG_SKIP, 32'h0000_0000);
		write_reg(cmbg_pkg::REG_PACK_MODE, 32'h0000_0000);
		queue_beats(1, 1'b1);
		queue_beats(3, 1'b0);
		wait_idle();
		write_reg(cmbg_pkg::REG_SEED, 32'h8000_0000);
		queue_beats(1, 1'b1);
		queue_beats(1, 1'b0);
		wait_idle();

		// packed mode: one byte, then a partial one across a mode change
		write_reg(cmbg_pkg::REG_GAIN_NEG, 32'h1800_0000);
		write_reg(cmbg_pkg::REG_GAIN_POS, 32'h1c00_0000);
		write_reg(cmbg_pkg::REG_SEED, 32'h0123_4567);
		write_reg(cmbg_pkg::REG_PACK_MODE, 32'hffff_ffff);
		queue_beats(1, 1'b1);
		queue_beats(9, 1'b0);
		wait_idle();
		write_reg(cmbg_pkg::REG_PACK_MODE, 32'h0000_0000);
		queue_beats(1, 1'b0);
		wait_idle();
		write_reg(cmbg_pkg::REG_PACK_MODE, 32'h0000_0001);
		queue_beats(7, 1'b0);
		wait_idle();

		// longest skip, once
		write_reg(cmbg_pkg::REG_PACK_MODE, 32'h0000_0000);
		write_reg(cmbg_pkg::REG_SKIP, 32'hffff_ffff);
		queue_beats(1, 1'b0);
		wait_idle();

		// unused indexes must leave the registers alone
		for (int i = int'(cmbg_pkg::REG_PACK_MODE) + 1; i < 2 ** cmbg_pkg::CFG_IDX_W; i++)
			write_reg(i[cmbg_pkg::CFG_IDX_W-1:0], $urandom);
		write_reg(cmbg_pkg::REG_SKIP, 32'h0000_0000);
		queue_beats(2, 1'b0);
		wait_idle();

		// random phases, register writes in between
		issued = 0;
		phase = 0;
		while (issued < RAND_BEATS) begin
			if ($urandom_range(0, 1))
				write_reg(cmbg_pkg::REG_GAIN_NEG, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(cmbg_pkg::REG_GAIN_POS, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(cmbg_pkg::REG_SEED, pick_seed());
			if ($urandom_range(0, 1))
				write_reg(cmbg_pkg::REG_SKIP,
					($urandom_range(0, 7) == 0) ? $urandom_range(4, 24)
					: $urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0)
				write_reg(cmbg_pkg::REG_PACK_MODE, $urandom);
			if ($urandom_range(0, 15) == 0)
				write_reg(cmbg_pkg::CFG_IDX_W'($urandom_range(
					int'(cmbg_pkg::REG_PACK_MODE) + 1, 2 ** cmbg_pkg::CFG_IDX_W - 1)),
					$urandom);
			count = $urandom_range(10, 60);
			if ($urandom_range(0, 1)) begin
				queue_beats(1, 1'b1);
				issued++;
			end
			for (int i = 0; i < count; i++)
				request_queue.push_back($urandom_range(0, 11) == 0);
			issued += count;
			// receiver holds off while the sender keeps offering
			if (phase == 5 || phase == 23)
				hold_cycles = 600;
			phase++;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (owed_values.size() != 0)
			report_mismatch("results still outstanding");
		if (err_count == 0) begin
			$display("chaotic_map_bit_generator_test: clean");
		end else begin
			$display("chaotic_map_bit_generator_test: errors");
		end
		$finish;
	end

endmodule
